/* hw/rtl/max_heap_priority_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH

`define MHPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define MHPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants and types of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_SEL,
        S_DN_CMP,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CMP_PUSH,
        CMP_SIBLING,
        CMP_CHILD
    } t_cmp_sel;

endpackage

`default_nettype wire

/* hw/rtl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/mhpq_cmp.sv */
// ----------------------------------------------------------------------------
// mhpq_cmp
// Shared signed greater-than unit with operand selection per sift step.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cmp (
    input  wire mhpq_pkg::t_cmp_sel                   i_sel,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]   i_val,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]   i_child,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]   i_rd_data,
    output logic                                      o_gt
);

    always_comb begin
        unique case (i_sel)
            mhpq_pkg::CMP_PUSH:    o_gt = i_val > i_rd_data;
            mhpq_pkg::CMP_SIBLING: o_gt = i_rd_data > i_child;
            mhpq_pkg::CMP_CHILD:   o_gt = i_child > i_val;
            default:               o_gt = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap of signed 32-bit values held in one RAM, with push and pop.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): i_opcode selects push of i_value or pop
// of the maximum. Output channel (o_valid / i_ready): one result transaction
// per input transaction with the popped value, the new maximum, its valid
// flag, the entry count and an error flag for push on full or pop on empty.
// One transaction is in work at a time; o_ready is high only while idle.
// A push rises level by level toward the root, at most log2(CAPACITY)
// levels; a pop sinks level by level. The single RAM read port sets the
// pace: each level needs one read for a push and two reads plus up to two
// compares for a pop, all through one shared comparator. Errors and a pop
// of the last entry skip the sift and go straight to the result.
// The result sits in an output register; the next transaction is accepted
// while it waits. If that next one finishes before the receiver takes the
// first, it holds until i_ready frees the register.
// Reset empties the heap at once; the RAM itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_heap_priority_queue_assert.svh"

module max_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int KW      = AW + 2
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_opcode,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]   i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed      [mhpq_pkg::DATA_W-1:0]   o_popped_value,
    output logic signed      [mhpq_pkg::DATA_W-1:0]   o_top_value,
    output logic                                      o_top_valid,
    output logic             [CW-1:0]                 o_entry_count,
    output logic                                      o_op_error
);

    mhpq_pkg::t_state r_state, n_state;

    logic        [CW-1:0]                 r_count;
    logic signed [mhpq_pkg::DATA_W-1:0]   r_top;
    logic signed [mhpq_pkg::DATA_W-1:0]   r_val;
    logic signed [mhpq_pkg::DATA_W-1:0]   r_child;
    logic signed [mhpq_pkg::DATA_W-1:0]   r_popped;
    logic        [AW-1:0]                 r_pos;
    logic        [AW-1:0]                 r_kid;
    logic                                 r_err;

    logic                                 w_in_fire;
    logic                                 w_out_load;
    logic                                 w_gt;
    logic                                 w_wr_en;
    logic        [AW-1:0]                 w_wr_addr;
    logic signed [mhpq_pkg::DATA_W-1:0]   w_wr_data;
    logic        [AW-1:0]                 w_rd_addr;
    logic signed [mhpq_pkg::DATA_W-1:0]   w_rd_data;
    mhpq_pkg::t_cmp_sel                   w_cmp_sel;

    logic        [KW-1:0]                 w_left;
    logic        [KW-1:0]                 w_right;
    logic        [KW-1:0]                 w_kid_left;
    logic        [KW-1:0]                 w_count_k;
    logic        [AW-1:0]                 w_parent;
    logic        [AW-1:0]                 w_last;

    assign w_left     = (KW'(r_pos) << 1) + KW'(1);
    assign w_right    = KW'(r_kid) + KW'(1);
    assign w_kid_left = (KW'(r_kid) << 1) + KW'(1);
    assign w_count_k  = KW'(r_count);
    assign w_parent   = (r_pos - AW'(1)) >> 1;
    assign w_last     = AW'(r_count - CW'(1));

    assign w_in_fire  = i_valid && o_ready;
    assign w_out_load = (r_state == mhpq_pkg::S_DONE) && (!o_valid || i_ready);

    mhpq_ram #(
        .WIDTH (mhpq_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    mhpq_cmp u_cmp (
        .i_sel     (w_cmp_sel),
        .i_val     (r_val),
        .i_child   (r_child),
        .i_rd_data (w_rd_data),
        .o_gt      (w_gt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    if (i_opcode == mhpq_pkg::OP_PUSH) begin
                        n_state = (r_count == CW'(CAPACITY)) ? mhpq_pkg::S_DONE
                                                             : mhpq_pkg::S_PUSH_CHK;
                    end else begin
                        n_state = (r_count <= CW'(1)) ? mhpq_pkg::S_DONE
                                                      : mhpq_pkg::S_POP_LAST;
                    end
                end
            end
            mhpq_pkg::S_PUSH_CHK: begin
                n_state = (r_pos == '0) ? mhpq_pkg::S_FIN : mhpq_pkg::S_PUSH_CMP;
            end
            mhpq_pkg::S_PUSH_CMP: begin
                n_state = w_gt ? mhpq_pkg::S_PUSH_CHK : mhpq_pkg::S_FIN;
            end
            mhpq_pkg::S_POP_LAST: begin
                n_state = (KW'(1) < w_count_k) ? mhpq_pkg::S_DN_RDL : mhpq_pkg::S_FIN;
            end
            mhpq_pkg::S_DN_RDL: begin
                n_state = mhpq_pkg::S_DN_RDR;
            end
            mhpq_pkg::S_DN_RDR: begin
                n_state = (w_right < w_count_k) ? mhpq_pkg::S_DN_SEL : mhpq_pkg::S_DN_CMP;
            end
            mhpq_pkg::S_DN_SEL: begin
                n_state = mhpq_pkg::S_DN_CMP;
            end
            mhpq_pkg::S_DN_CMP: begin
                if (w_gt && (w_kid_left < w_count_k)) begin
                    n_state = mhpq_pkg::S_DN_RDL;
                end else begin
                    n_state = mhpq_pkg::S_FIN;
                end
            end
            mhpq_pkg::S_FIN: begin
                n_state = mhpq_pkg::S_DONE;
            end
            mhpq_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = mhpq_pkg::S_IDLE;
                end
            end
            default: n_state = mhpq_pkg::S_IDLE;
        endcase
    end

    // RAM and comparator control
    always_comb begin
        o_ready   = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_val;
        w_rd_addr = r_pos;
        w_cmp_sel = mhpq_pkg::CMP_CHILD;
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                o_ready   = 1'b1;
                w_rd_addr = w_last;
            end
            mhpq_pkg::S_PUSH_CHK: begin
                w_rd_addr = w_parent;
            end
            mhpq_pkg::S_PUSH_CMP: begin
                w_cmp_sel = mhpq_pkg::CMP_PUSH;
                w_wr_en   = w_gt;
                w_wr_data = w_rd_data;
            end
            mhpq_pkg::S_DN_RDL: begin
                w_rd_addr = AW'(w_left);
            end
            mhpq_pkg::S_DN_RDR: begin
                w_rd_addr = AW'(w_right);
            end
            mhpq_pkg::S_DN_SEL: begin
                w_cmp_sel = mhpq_pkg::CMP_SIBLING;
            end
            mhpq_pkg::S_DN_CMP: begin
                w_cmp_sel = mhpq_pkg::CMP_CHILD;
                w_wr_en   = w_gt;
                w_wr_data = r_child;
            end
            mhpq_pkg::S_FIN: begin
                w_wr_en = 1'b1;
            end
            mhpq_pkg::S_POP_LAST,
            mhpq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhpq_pkg::S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (w_in_fire) begin
                if (i_opcode == mhpq_pkg::OP_PUSH) begin
                    if (r_count != CW'(CAPACITY)) begin
                        r_count <= r_count + CW'(1);
                    end
                end else if (r_count != '0) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
    end

    // sift datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    r_popped <= '0;
                    r_err    <= 1'b0;
                    r_val    <= i_value;
                    r_pos    <= AW'(r_count);
                    if (i_opcode == mhpq_pkg::OP_PUSH) begin
                        r_err <= (r_count == CW'(CAPACITY));
                    end else if (r_count == '0) begin
                        r_err <= 1'b1;
                    end else begin
                        r_popped <= r_top;
                    end
                end
            end
            mhpq_pkg::S_PUSH_CHK: begin
                r_kid <= w_parent;
            end
            mhpq_pkg::S_PUSH_CMP: begin
                if (w_gt) begin
                    r_pos <= r_kid;
                end
            end
            mhpq_pkg::S_POP_LAST: begin
                r_val <= w_rd_data;
                r_pos <= '0;
            end
            mhpq_pkg::S_DN_RDL: begin
                r_kid <= AW'(w_left);
            end
            mhpq_pkg::S_DN_RDR: begin
                r_child <= w_rd_data;
            end
            mhpq_pkg::S_DN_SEL: begin
                if (w_gt) begin
                    r_child <= w_rd_data;
                    r_kid   <= AW'(w_right);
                end
            end
            mhpq_pkg::S_DN_CMP: begin
                if (w_gt) begin
                    r_pos <= r_kid;
                    if (r_pos == '0) begin
                        r_top <= r_child;
                    end
                end
            end
            mhpq_pkg::S_FIN: begin
                if (r_pos == '0) begin
                    r_top <= r_val;
                end
            end
            mhpq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_popped_value <= r_popped;
            o_top_value    <= (r_count != '0) ? r_top : '0;
            o_top_valid    <= (r_count != '0);
            o_entry_count  <= r_count;
            o_op_error     <= r_err;
        end
    end

    `MHPQ_ASSERT_IMPL(a_write_in_heap, i_clk, i_rst_n, w_wr_en, CW'(r_pos) < r_count)
    `MHPQ_ASSERT_NEXT(a_pop_empty_err, i_clk, i_rst_n,
        w_in_fire && (i_opcode == mhpq_pkg::OP_POP) && (r_count == '0),
        (r_state == mhpq_pkg::S_DONE) && r_err && (r_count == '0))
    `MHPQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, o_valid,
        (o_entry_count <= CW'(CAPACITY)) && (o_top_valid == (o_entry_count != '0)))

endmodule

`default_nettype wire

/* verif/max_heap_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// max_heap_priority_queue_tb
// Self-checking testbench for the binary max-heap priority queue.
// A short stimulus table covers the value extremes, push and pop, pop on
// empty and a pop that empties the heap. Random traffic follows: fill runs
// that end in pushes on a full heap, drain runs that end in pops on an empty
// heap, and mixed runs with a random push share. A behavioral heap predicts
// every result. Traffic runs under four throttling phases on both channels.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_tb;

    localparam int CAPACITY     = mhpq_pkg::CAPACITY_DEF;
    localparam int DW           = mhpq_pkg::DATA_W;
    localparam int CW           = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic PUSH = mhpq_pkg::OP_PUSH;
    localparam logic POP  = mhpq_pkg::OP_POP;

    localparam int SEND_IDLE_PCT  [4] = '{0, 80, 0, 21};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 80, 21};

    typedef struct packed {
        logic signed [DW-1:0] popped_value;
        logic signed [DW-1:0] top_value;
        logic                 top_valid;
        logic [CW-1:0]        entry_count;
        logic                 op_error;
    } t_heap_result;

    typedef struct packed {
        logic                 op;
        logic signed [DW-1:0] value;
        logic                 fixed;
        t_heap_result         res;
    } t_stim_row;

    typedef enum int {
        SEG_MIX,
        SEG_FILL,
        SEG_DRAIN
    } t_seg_mode;

    localparam int DIRECTED_ROWS = 24;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{POP,  32'sd0,         1'b1, '{32'sd0, 32'sd0, 1'b0, 9'd0, 1'b1}},
        '{PUSH, 32'h7FFFFFFF,   1'b1, '{32'sd0, 32'h7FFFFFFF, 1'b1, 9'd1, 1'b0}},
        '{PUSH, 32'h80000000,   1'b1, '{32'sd0, 32'h7FFFFFFF, 1'b1, 9'd2, 1'b0}},
        '{POP,  32'sd0,         1'b1, '{32'h7FFFFFFF, 32'h80000000, 1'b1, 9'd1, 1'b0}},
        '{POP,  32'h55555555,   1'b1, '{32'h80000000, 32'sd0, 1'b0, 9'd0, 1'b0}},
        '{POP,  32'h7FFFFFFF,   1'b1, '{32'sd0, 32'sd0, 1'b0, 9'd0, 1'b1}},
        '{PUSH, 32'sd0,         1'b0, '0},
        '{PUSH, -32'sd1,        1'b0, '0},
        '{PUSH, 32'sd1,         1'b0, '0},
        '{PUSH, 32'h80000000,   1'b0, '0},
        '{PUSH, 32'h7FFFFFFF,   1'b0, '0},
        '{PUSH, 32'h55555555,   1'b0, '0},
        '{PUSH, 32'hAAAAAAAA,   1'b0, '0},
        '{PUSH, 32'sd5,         1'b0, '0},
        '{PUSH, 32'sd5,         1'b0, '0},
        '{PUSH, -32'sd1,        1'b0, '0},
        '{POP,  32'hFFFFFFFF,   1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0},
        '{PUSH, 32'sd3,         1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0},
        '{POP,  32'sd0,         1'b0, '0}
    };

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 i_opcode = PUSH;
    logic signed [DW-1:0] i_value  = '0;
    logic                 i_ready  = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic signed [DW-1:0] o_popped_value;
    logic signed [DW-1:0] o_top_value;
    logic                 o_top_valid;
    logic [CW-1:0]        o_entry_count;
    logic                 o_op_error;

    logic signed [DW-1:0] heap_ref [CAPACITY];
    int                   heap_fill = 0;
    t_heap_result         pending_results [$];
    int                   mismatch_count = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   random_sent    = 0;
    int                   cycle_count    = 0;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_popped_value(o_popped_value),
        .o_top_value   (o_top_value),
        .o_top_valid   (o_top_valid),
        .o_entry_count (o_entry_count),
        .o_op_error    (o_op_error)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    function automatic t_heap_result heap_apply_op(input logic op,
                                                   input logic signed [DW-1:0] val);
        t_heap_result         r;
        int                   pos;
        int                   up;
        int                   kid;
        logic signed [DW-1:0] swap;
        r = '0;
        if (op == PUSH) begin
            if (heap_fill >= CAPACITY) begin
                r.op_error = 1'b1;
            end else begin
                pos = heap_fill;
                heap_ref[pos] = val;
                heap_fill++;
                while (pos > 0) begin
                    up = (pos - 1) / 2;
                    if (heap_ref[pos] <= heap_ref[up]) break;
                    swap          = heap_ref[pos];
                    heap_ref[pos] = heap_ref[up];
                    heap_ref[up]  = swap;
                    pos           = up;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.op_error = 1'b1;
            end else begin
                r.popped_value = heap_ref[0];
                heap_fill--;
                heap_ref[0] = heap_ref[heap_fill];
                pos = 0;
                kid = 1;
                while (kid < heap_fill) begin
                    if (kid + 1 < heap_fill && heap_ref[kid + 1] > heap_ref[kid]) kid++;
                    if (heap_ref[kid] <= heap_ref[pos]) break;
                    swap          = heap_ref[kid];
                    heap_ref[kid] = heap_ref[pos];
                    heap_ref[pos] = swap;
                    pos           = kid;
                    kid           = 2 * pos + 1;
                end
            end
        end
        r.top_valid   = (heap_fill > 0);
        r.top_value   = (heap_fill > 0) ? heap_ref[0] : '0;
        r.entry_count = CW'(heap_fill);
        return r;
    endfunction

    function automatic logic signed [DW-1:0] random_value();
        case ($urandom_range(9, 0))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2, 3:    return $signed($urandom_range(16, 0)) - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic op, input logic signed [DW-1:0] val,
                             input logic fixed, input t_heap_result fixed_res);
        t_heap_result predicted;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (!o_ready);
        predicted = heap_apply_op(op, val);
        pending_results.push_back(fixed ? fixed_res : predicted);
    endtask

    task automatic send_random(input logic op);
        int phase;
        phase = random_sent * 4 / RANDOM_ITEMS;
        if (phase > 3) phase = 3;
        send_idle_pct  = SEND_IDLE_PCT[phase];
        recv_stall_pct = RECV_STALL_PCT[phase];
        send_item(op, random_value(), 1'b0, '0);
        random_sent++;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_heap_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, popped_value %0d",
                         $time, o_popped_value);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_popped_value !== want.popped_value) begin
                    $display("%0t: popped_value expected %0d, actual %0d",
                             $time, want.popped_value, o_popped_value);
                    mismatch_count++;
                end
                if (o_top_value !== want.top_value) begin
                    $display("%0t: top_value expected %0d, actual %0d",
                             $time, want.top_value, o_top_value);
                    mismatch_count++;
                end
                if (o_top_valid !== want.top_valid) begin
                    $display("%0t: top_valid expected %0b, actual %0b",
                             $time, want.top_valid, o_top_valid);
                    mismatch_count++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d, actual %0d",
                             $time, want.entry_count, o_entry_count);
                    mismatch_count++;
                end
                if (o_op_error !== want.op_error) begin
                    $display("%0t: op_error expected %0b, actual %0b",
                             $time, want.op_error, o_op_error);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int        seg;
        int        n;
        int        push_pct;
        t_seg_mode mode;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) begin
            send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].fixed,
                      DIRECTED[i].res);
        end

        seg = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (seg == 0) begin
                mode = SEG_FILL;
            end else if (seg == 1) begin
                mode = SEG_DRAIN;
            end else begin
                case ($urandom_range(7, 0))
                    0:       mode = SEG_FILL;
                    1:       mode = SEG_DRAIN;
                    default: mode = SEG_MIX;
                endcase
            end
            case (mode)
                SEG_FILL: begin
                    while (heap_fill < CAPACITY && random_sent < RANDOM_ITEMS) begin
                        send_random(PUSH);
                    end
                    repeat ($urandom_range(3, 1)) send_random(PUSH);
                end
                SEG_DRAIN: begin
                    while (heap_fill > 0 && random_sent < RANDOM_ITEMS) begin
                        send_random(POP);
                    end
                    repeat ($urandom_range(3, 1)) send_random(POP);
                end
                default: begin
                    n        = $urandom_range(80, 10);
                    push_pct = $urandom_range(85, 15);
                    repeat (n) begin
                        send_random(($urandom_range(99, 0) < push_pct) ? PUSH : POP);
                    end
                end
            endcase
            seg++;
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/mhpq_cmp.sv
hw/rtl/max_heap_priority_queue.sv
verif/max_heap_priority_queue_tb.sv
